### src/rcnd_pkg.sv
// Shared types, constants and helpers for the rotation-code nibble decryptor.
`timescale 1ns / 1ps
`default_nettype none
package rcnd_pkg;

  localparam int unsigned WORD_W        = 16;
  localparam int unsigned CODE_BITS_DEF = 16;
  localparam int unsigned OFFSET_W      = 4;
  localparam int unsigned NIBBLE_W      = 4;
  localparam int unsigned GROUPS        = 4;
  localparam int unsigned GROUP_W       = 2;
  localparam int unsigned TABLE_W       = 64;
  localparam int unsigned LANES         = 16;
  localparam int unsigned LANE_PAIRS    = LANES / 2;
  localparam int unsigned REG_INDEX_W   = 3;
  localparam int unsigned BYTE_W        = 8;

  // Register map: base codes first, inverse codebooks after them.
  localparam logic [REG_INDEX_W-1:0] REG_BASE_CODE_0     = 3'd0;
  localparam logic [REG_INDEX_W-1:0] REG_INVERSE_TABLE_0 = 3'd4;

  // One candidate: a rotated word and the rotation count that produced it.
  typedef struct packed {
    logic [WORD_W-1:0]   value;
    logic [OFFSET_W-1:0] offset;
  } cand_t;

  // Decode result of one cipher word.
  typedef struct packed {
    logic                ok;
    logic [NIBBLE_W-1:0] nibble;
  } dec_t;

  // Keep the left (lower rotation) candidate unless the right one is strictly smaller.
  function automatic cand_t pick_min(input cand_t left, input cand_t right);
    pick_min = (right.value < left.value) ? right : left;
  endfunction

endpackage
`default_nettype wire

### src/rcnd_lane.sv
// One lane pair: two right rotations of a word, the smaller one registered.
`timescale 1ns / 1ps
`default_nettype none
module rcnd_lane #(
  parameter int unsigned CODE_BITS = rcnd_pkg::CODE_BITS_DEF,
  parameter int unsigned PAIR      = 0
) (
  input  wire logic                        clk,
  input  wire logic [rcnd_pkg::WORD_W-1:0] word,
  output rcnd_pkg::cand_t                  cand
);

  // Lanes past the word width repeat rotation zero; ties keep the lower lane.
  localparam int unsigned ROT_A = (2 * PAIR < CODE_BITS) ? 2 * PAIR : 0;
  localparam int unsigned ROT_B = (2 * PAIR + 1 < CODE_BITS) ? 2 * PAIR + 1 : 0;

  logic [CODE_BITS-1:0]   w;
  logic [2*CODE_BITS-1:0] doubled;
  rcnd_pkg::cand_t        cand_a;
  rcnd_pkg::cand_t        cand_b;
  rcnd_pkg::cand_t        cand_next;

  assign w       = word[CODE_BITS-1:0];
  assign doubled = {w, w};

  always_comb begin
    cand_a = '0;
    cand_b = '0;
    cand_a.value[CODE_BITS-1:0] = doubled[ROT_A +: CODE_BITS];
    cand_b.value[CODE_BITS-1:0] = doubled[ROT_B +: CODE_BITS];
    cand_a.offset = rcnd_pkg::OFFSET_W'(ROT_A);
    cand_b.offset = rcnd_pkg::OFFSET_W'(ROT_B);
    cand_next = rcnd_pkg::pick_min(cand_a, cand_b);
  end

  always_ff @(posedge clk) begin
    cand <= cand_next;
  end

endmodule
`default_nettype wire

### src/rcnd_merge.sv
// Registered minimum tree over the lane pair results of one word.
`timescale 1ns / 1ps
`default_nettype none
module rcnd_merge (
  input  wire logic      clk,
  input  rcnd_pkg::cand_t cand [rcnd_pkg::LANE_PAIRS],
  output rcnd_pkg::cand_t best
);

  localparam int unsigned L1 = rcnd_pkg::LANE_PAIRS / 2;
  localparam int unsigned L2 = L1 / 2;

  rcnd_pkg::cand_t lvl1 [L1];
  rcnd_pkg::cand_t lvl2_next [L2];
  rcnd_pkg::cand_t lvl2 [L2];
  rcnd_pkg::cand_t best_next;

  // Two tree levels, then a register.
  always_comb begin
    for (int i = 0; i < L1; i++) begin
      lvl1[i] = rcnd_pkg::pick_min(cand[2*i], cand[2*i+1]);
    end
    for (int i = 0; i < L2; i++) begin
      lvl2_next[i] = rcnd_pkg::pick_min(lvl1[2*i], lvl1[2*i+1]);
    end
  end

  always_ff @(posedge clk) begin
    lvl2 <= lvl2_next;
  end

  // Final level; ties keep the left side, the lower rotation.
  always_comb begin
    best_next = lvl2[0];
    for (int i = 1; i < L2; i++) begin
      best_next = rcnd_pkg::pick_min(best_next, lvl2[i]);
    end
  end

  always_ff @(posedge clk) begin
    best <= best_next;
  end

endmodule
`default_nettype wire

### src/rcnd_codebook.sv
// Base code match and inverse codebook lookup for one word.
`timescale 1ns / 1ps
`default_nettype none
module rcnd_codebook (
  input  wire logic                         clk,
  input  rcnd_pkg::cand_t                   best,
  input  wire logic [rcnd_pkg::WORD_W-1:0]  base_code [rcnd_pkg::GROUPS],
  input  wire logic [rcnd_pkg::TABLE_W-1:0] inverse_table [rcnd_pkg::GROUPS],
  output rcnd_pkg::dec_t                    dec
);

  logic                          hit;
  logic [rcnd_pkg::GROUP_W-1:0]  group;
  rcnd_pkg::dec_t                dec_next;

  // Lowest-numbered matching group wins: scan downward so it is written last.
  always_comb begin
    hit   = 1'b0;
    group = '0;
    for (int g = rcnd_pkg::GROUPS - 1; g >= 0; g--) begin
      if (base_code[g] == best.value) begin
        hit   = 1'b1;
        group = rcnd_pkg::GROUP_W'(g);
      end
    end
    dec_next.ok     = hit;
    dec_next.nibble = hit ? inverse_table[group][best.offset * rcnd_pkg::NIBBLE_W +:
                                                 rcnd_pkg::NIBBLE_W]
                          : '0;
  end

  always_ff @(posedge clk) begin
    dec <= dec_next;
  end

endmodule
`default_nettype wire

### src/rotation_code_nibble_decrypt.sv
// Top level: config registers, rotation lanes, merge trees and codebook lookup.
//
//   channel   ports                                   handshake
//   request   cipher_high, cipher_low, last_pair      start, busy
//   result    plain_byte, fail, last_byte             done (one cycle)
//   config    wr_index, wr_data                       wr_en
//
// One request is taken every cycle while busy is low; done rises with the result,
// both held in the last pipeline register. The pipeline registers, in order, are
// the lane pairs, two tree stages, then the codebook lookup. busy is high only
// during reset, which clears the config registers and the pipeline valid bits.
// The result side has no stall, so nothing in the pipeline ever waits.
`timescale 1ns / 1ps
`default_nettype none
module rotation_code_nibble_decrypt #(
  parameter int unsigned CODE_BITS = rcnd_pkg::CODE_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output      logic                             busy,
  input  wire logic [rcnd_pkg::WORD_W-1:0]      cipher_high,
  input  wire logic [rcnd_pkg::WORD_W-1:0]      cipher_low,
  input  wire logic                             last_pair,
  output      logic                             done,
  output      logic [rcnd_pkg::BYTE_W-1:0]      plain_byte,
  output      logic                             fail,
  output      logic                             last_byte,
  input  wire logic                             wr_en,
  input  wire logic [rcnd_pkg::REG_INDEX_W-1:0] wr_index,
  input  wire logic [rcnd_pkg::TABLE_W-1:0]     wr_data
);

  localparam int unsigned DEPTH = 4;

  logic [rcnd_pkg::WORD_W-1:0]  base_code     [rcnd_pkg::GROUPS];
  logic [rcnd_pkg::TABLE_W-1:0] inverse_table [rcnd_pkg::GROUPS];

  logic             accept;
  logic [DEPTH-1:0] valid;
  logic [DEPTH-1:0] last;

  rcnd_pkg::cand_t cand_hi [rcnd_pkg::LANE_PAIRS];
  rcnd_pkg::cand_t cand_lo [rcnd_pkg::LANE_PAIRS];
  rcnd_pkg::cand_t best_hi;
  rcnd_pkg::cand_t best_lo;
  rcnd_pkg::dec_t  dec_hi;
  rcnd_pkg::dec_t  dec_lo;

  assign busy   = rst;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < rcnd_pkg::GROUPS; g++) begin
        base_code[g]     <= '0;
        inverse_table[g] <= '0;
      end
    end else if (wr_en) begin
      if (wr_index < rcnd_pkg::REG_INVERSE_TABLE_0) begin
        base_code[rcnd_pkg::GROUP_W'(wr_index - rcnd_pkg::REG_BASE_CODE_0)] <=
          wr_data[rcnd_pkg::WORD_W-1:0];
      end else begin
        inverse_table[rcnd_pkg::GROUP_W'(wr_index - rcnd_pkg::REG_INVERSE_TABLE_0)] <= wr_data;
      end
    end
  end

  // Advance request markers alongside the datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[DEPTH-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    last <= {last[DEPTH-2:0], last_pair};
  end

  for (genvar p = 0; p < rcnd_pkg::LANE_PAIRS; p++) begin : g_lane
    rcnd_lane #(.CODE_BITS(CODE_BITS), .PAIR(p)) u_lane_hi (
      .clk  (clk),
      .word (cipher_high),
      .cand (cand_hi[p])
    );
    rcnd_lane #(.CODE_BITS(CODE_BITS), .PAIR(p)) u_lane_lo (
      .clk  (clk),
      .word (cipher_low),
      .cand (cand_lo[p])
    );
  end

  rcnd_merge u_merge_hi (.clk(clk), .cand(cand_hi), .best(best_hi));
  rcnd_merge u_merge_lo (.clk(clk), .cand(cand_lo), .best(best_lo));

  rcnd_codebook u_codebook_hi (
    .clk           (clk),
    .best          (best_hi),
    .base_code     (base_code),
    .inverse_table (inverse_table),
    .dec           (dec_hi)
  );

  rcnd_codebook u_codebook_lo (
    .clk           (clk),
    .best          (best_lo),
    .base_code     (base_code),
    .inverse_table (inverse_table),
    .dec           (dec_lo)
  );

  // Drop the byte to zero when either word found no group.
  assign done       = valid[DEPTH-1];
  assign fail       = !(dec_hi.ok && dec_lo.ok);
  assign plain_byte = (dec_hi.ok && dec_lo.ok) ? {dec_hi.nibble, dec_lo.nibble} : '0;
  assign last_byte  = last[DEPTH-1];

`ifndef SYNTHESIS
  a_done_follows_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, DEPTH))
    else $error("result strobe does not match accepted request");

  a_last_carried: assert property (@(posedge clk) disable iff (rst)
    done |-> last_byte == $past(last_pair, DEPTH))
    else $error("last marker lost in pipeline");

  a_fail_zero_byte: assert property (@(posedge clk) disable iff (rst)
    done && fail |-> plain_byte == '0)
    else $error("failed decode produced nonzero byte");

  a_offset_range: assert property (@(posedge clk) disable iff (rst)
    valid[DEPTH-2] |-> (32'(best_hi.offset) < CODE_BITS) && (32'(best_lo.offset) < CODE_BITS))
    else $error("rotation offset beyond word width");
`endif

endmodule
`default_nettype wire
